>>> rtl/apq_pkg.sv
package apq_pkg;

    // default sizes
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_MAX_CPUS    = 16;

    // opcodes
    localparam logic [1:0] OP_WAKE    = 2'd0;
    localparam logic [1:0] OP_SCHED   = 2'd1;
    localparam logic [1:0] OP_PREEMPT = 2'd2;

    // scheduling modes
    localparam logic [1:0] MODE_AGING = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_CPUS   = 2'd2;

    // aged priority: 8-bit prio plus 32x16 product
    localparam int AGED_W = 49;

    // one stored process
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  prio;
        logic [7:0]  pid;
    } entry_t;

    // one result item
    typedef struct packed {
        logic       ov;
        logic [3:0] qc;
        logic       qv;
        logic [7:0] pp;
        logic       pv;
    } res_t;

endpackage

>>> rtl/aging_priority_ready_queue.sv
// Aging priority ready queue with a per-CPU running table.
// s_ channel takes one operation item (wake, schedule cpu, preempt cpu);
// m_ channel returns exactly one result item for every accepted item.
// Registers must be written by the user through cfg_wr_en/cfg_index/cfg_wdata while idle; not enforced.
// One item is worked on at a time; s_tready is high only between items,
// but a new item is taken while the previous result still waits on m_.
// A wake appends the process; in aging mode with all CPUs busy it then
// streams the running table through the aged unit to find a preemption
// target. A schedule takes the queue head, or in aging mode streams every
// queue entry through the aged unit and takes the highest aged priority.
// A preempt of a busy cpu first requeues its running process, then
// schedules. A removal shifts the tail down one entry per cycle.
// Reset empties the queue and marks every CPU idle; no clearing pass.
// When m_tready is low the result stays in the output register and the
// block finishes the next item, then holds it until the output frees.
module aging_priority_ready_queue
    import apq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MAX_CPUS    = DEF_MAX_CPUS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // opcode, cpu_index, process_id, base_priority, now_time
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // picked_valid, picked_process, preempt_valid, preempt_cpu, queue_overflow
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int TW  = (AW > CIW) ? AW : CIW;
    localparam int LIM = (MAX_CPUS < 16) ? MAX_CPUS : 16;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_PUSH     = 11'b00000000010,
        ST_RUN_RD   = 11'b00000000100,
        ST_RUN_PUSH = 11'b00000001000,
        ST_FILL     = 11'b00000010000,
        ST_SCAN     = 11'b00000100000,
        ST_EVAL     = 11'b00001000000,
        ST_SEL_RD   = 11'b00010000000,
        ST_SEL_WR   = 11'b00100000000,
        ST_SHIFT    = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [3:0]          cpu_reg, cpu_next;
    logic [7:0]          pid_reg, pid_next;
    logic [7:0]          prio_reg, prio_next;
    logic [31:0]         now_reg, now_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [MAX_CPUS-1:0] busy_reg, busy_next;
    res_t                res_reg, res_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                src_run_reg, src_run_next;
    logic [TW-1:0]       si_reg, si_next;
    logic                iss_on_reg, iss_on_next;
    logic [TW-1:0]       last_reg, last_next;
    logic                rdv_reg;
    logic [TW-1:0]       rdtag_reg;
    logic [AGED_W-1:0]   best_reg, best_next;
    logic [AW-1:0]       sel_reg, sel_next;
    logic [CIW-1:0]      target_reg, target_next;
    logic [1:0]          mode_reg;
    logic [15:0]         weight_reg;
    logic [4:0]          ccount_reg;

    // memory ports
    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr;
    entry_t        q_wdata, q_rdata;
    logic          r_we;
    logic [CIW-1:0] r_waddr, r_raddr;
    entry_t        r_wdata, r_rdata;

    // aged unit
    logic              a_in_valid;
    entry_t            a_src;
    logic              a_valid;
    logic [TW-1:0]     a_tag;
    logic [AGED_W-1:0] a_value;

    logic [4:0]        nact;
    logic              any_idle;
    logic [CIW-1:0]    cpu_a;
    logic              cpu_ok;
    logic              q_full;
    logic [AGED_W-1:0] mine;
    logic              issue;

    apq_ram #(.W($bits(entry_t)), .D(QUEUE_DEPTH)) u_qram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    apq_ram #(.W($bits(entry_t)), .D(MAX_CPUS)) u_rram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign a_src      = src_run_reg ? r_rdata : q_rdata;
    assign a_in_valid = rdv_reg;

    apq_aged #(.TW(TW)) u_aged (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_in_valid),
        .in_tag    (rdtag_reg),
        .in_prio   (a_src.prio),
        .in_stamp  (a_src.stamp),
        .now       (now_reg),
        .weight    (weight_reg),
        .out_valid (a_valid),
        .out_tag   (a_tag),
        .out_value (a_value)
    );

    // active cpu count and idle check
    always_comb begin
        if (ccount_reg == 5'd0) begin
            nact = 5'd1;
        end else if (ccount_reg > 5'(LIM)) begin
            nact = 5'(LIM);
        end else begin
            nact = ccount_reg;
        end
        any_idle = 1'b0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            if ((i < 32'(nact)) && !busy_reg[i]) begin
                any_idle = 1'b1;
            end
        end
    end

    assign cpu_a    = CIW'(cpu_reg);
    assign cpu_ok   = {1'b0, cpu_reg} < nact;
    assign q_full   = count_reg >= CW'(QUEUE_DEPTH);
    assign mine     = {41'd0, prio_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && iss_on_reg;

    // operation sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cpu_next       = cpu_reg;
        pid_next       = pid_reg;
        prio_next      = prio_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        src_run_next   = src_run_reg;
        si_next        = si_reg;
        iss_on_next    = iss_on_reg;
        last_next      = last_reg;
        best_next      = best_reg;
        sel_next       = sel_reg;
        target_next    = target_reg;
        q_we           = 1'b0;
        q_waddr        = count_reg[AW-1:0];
        q_wdata        = '{stamp: now_reg, prio: prio_reg, pid: pid_reg};
        q_raddr        = si_reg[AW-1:0];
        r_we           = 1'b0;
        r_waddr        = cpu_a;
        r_wdata        = q_rdata;
        r_raddr        = issue ? si_reg[CIW-1:0] : cpu_a;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tdata[1:0];
                    cpu_next  = s_tdata[5:2];
                    pid_next  = s_tdata[13:6];
                    prio_next = s_tdata[21:14];
                    now_next  = s_tdata[53:22];
                    res_next  = '0;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // dispatch by opcode; wake appends the new process
                if (op_reg == OP_WAKE) begin
                    if (q_full) begin
                        res_next.ov = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        q_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (mode_reg == MODE_AGING && !any_idle) begin
                            src_run_next = 1'b1;
                            si_next      = '0;
                            iss_on_next  = 1'b1;
                            last_next    = TW'(nact - 5'd1);
                            best_next    = mine;
                            target_next  = '0;
                            state_next   = ST_SCAN;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end else if ((op_reg == OP_SCHED || op_reg == OP_PREEMPT) && cpu_ok) begin
                    if (op_reg == OP_PREEMPT && busy_reg[cpu_a]) begin
                        state_next = ST_RUN_RD;
                    end else begin
                        state_next = ST_FILL;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN_RD: begin
                // running slot read is issued on r_raddr
                state_next = ST_RUN_PUSH;
            end
            ST_RUN_PUSH: begin
                // requeue the running process stamped with now
                if (q_full) begin
                    res_next.ov = 1'b1;
                end else begin
                    q_we       = 1'b1;
                    q_wdata    = '{stamp: now_reg, prio: r_rdata.prio, pid: r_rdata.pid};
                    count_next = count_reg + 1'b1;
                end
                busy_next[cpu_a] = 1'b0;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                if (count_reg == '0) begin
                    busy_next[cpu_a] = 1'b0;
                    state_next = ST_DONE;
                end else if (mode_reg == MODE_AGING) begin
                    src_run_next = 1'b0;
                    si_next      = '0;
                    iss_on_next  = 1'b1;
                    last_next    = TW'(count_reg - 1'b1);
                    state_next   = ST_SCAN;
                end else begin
                    sel_next   = '0;
                    state_next = ST_SEL_RD;
                end
            end
            ST_SCAN: begin
                // stream reads into the aged unit, compare results in order
                if (iss_on_reg) begin
                    if (si_reg == last_reg) begin
                        iss_on_next = 1'b0;
                    end else begin
                        si_next = si_reg + 1'b1;
                    end
                end
                if (a_valid) begin
                    if (!src_run_reg) begin
                        if (a_tag == '0 || a_value > best_reg) begin
                            best_next = a_value;
                            sel_next  = a_tag[AW-1:0];
                        end
                    end else if (a_value < best_reg) begin
                        best_next   = a_value;
                        target_next = a_tag[CIW-1:0];
                    end
                    if (a_tag == last_reg) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (src_run_reg) begin
                    if (best_reg < mine) begin
                        res_next.qv = 1'b1;
                        res_next.qc = 4'(target_reg);
                    end
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_RD: begin
                q_raddr    = sel_reg;
                state_next = ST_SEL_WR;
            end
            ST_SEL_WR: begin
                // selected entry goes to the running slot, then close the gap
                r_we             = 1'b1;
                busy_next[cpu_a] = 1'b1;
                res_next.pv      = 1'b1;
                res_next.pp      = q_rdata.pid;
                q_raddr          = sel_reg + 1'b1;
                if (CW'(sel_reg) + 1'b1 < count_reg) begin
                    state_next = ST_SHIFT;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                q_we    = 1'b1;
                q_waddr = sel_reg;
                q_wdata = q_rdata;
                q_raddr = sel_reg + 2'd2;
                if (CW'(sel_reg) + 2'd2 < count_reg) begin
                    sel_next = sel_reg + 1'b1;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
            iss_on_reg    <= 1'b0;
            rdv_reg       <= 1'b0;
            mode_reg      <= 2'd0;
            weight_reg    <= 16'd0;
            ccount_reg    <= 5'd1;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            iss_on_reg    <= iss_on_next;
            rdv_reg       <= issue;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_wdata[1:0];
                    CFG_WEIGHT: weight_reg <= cfg_wdata;
                    CFG_CPUS:   ccount_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        cpu_reg     <= cpu_next;
        pid_reg     <= pid_next;
        prio_reg    <= prio_next;
        now_reg     <= now_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        src_run_reg <= src_run_next;
        si_reg      <= si_next;
        last_reg    <= last_next;
        rdtag_reg   <= si_reg;
        best_reg    <= best_next;
        sel_reg     <= sel_next;
        target_reg  <= target_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.ov, out_reg.qc, out_reg.qv, out_reg.pp, out_reg.pv};

    // queue fill never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // a result never both places a process and asks for a preemption
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.pv && out_reg.qv))
        else $error("pick and preempt in one result");

    // placing a process marks its cpu busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL_WR) |=> busy_reg[$past(cpu_a)])
        else $error("cpu not busy after pick");

    // scan reads stay inside the scanned range
    assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (si_reg <= last_reg))
        else $error("scan read past last entry");

endmodule

>>> rtl/apq_ram.sv
module apq_ram #(
    parameter int W = 48,
    parameter int D = 64
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                        wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                        rdata
);

    logic [W-1:0] mem [D];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/apq_aged.sv
module apq_aged
    import apq_pkg::*;
#(
    parameter int TW = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [TW-1:0]     in_tag,
    input  logic [7:0]        in_prio,
    input  logic [31:0]       in_stamp,
    input  logic [31:0]       now,
    input  logic [15:0]       weight,
    output logic              out_valid,
    output logic [TW-1:0]     out_tag,
    output logic [AGED_W-1:0] out_value
);

    logic              v1_reg;
    logic [TW-1:0]     tag1_reg;
    logic [47:0]       prod_reg;
    logic [7:0]        prio1_reg;
    logic              v2_reg;
    logic [TW-1:0]     tag2_reg;
    logic [AGED_W-1:0] sum_reg;
    logic [31:0]       wait_time;

    assign wait_time = now - in_stamp;

    // stage one: waiting time times weight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        tag1_reg  <= in_tag;
        prod_reg  <= wait_time * weight;
        prio1_reg <= in_prio;
        // stage two: add static priority
        tag2_reg  <= tag1_reg;
        sum_reg   <= {1'b0, prod_reg} + {41'd0, prio1_reg};
    end

    assign out_valid = v2_reg;
    assign out_tag   = tag2_reg;
    assign out_value = sum_reg;

endmodule

>>> verif/aging_priority_ready_queue_tb.sv
module aging_priority_ready_queue_tb;
    import apq_pkg::*;

    localparam int          QDEPTH     = 64;
    localparam int          NCPU       = 16;
    localparam logic [1:0]  MODE_FCFS  = 2'd0;
    localparam logic [1:0]  MODE_RR    = 2'd1;
    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam logic [1:0]  OP_NONE    = 2'd3;
    localparam int          DRAIN_WAIT = 220;
    localparam longint      CYCLE_CAP  = 3000000;

    logic        aclk;
    logic        aresetn;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    aging_priority_ready_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // scheduler shadow state
    logic [7:0]  rq_pid   [QDEPTH];
    logic [7:0]  rq_prio  [QDEPTH];
    logic [31:0] rq_stamp [QDEPTH];
    int          rq_count;
    bit          cpu_busy  [NCPU];
    logic [7:0]  cpu_pid   [NCPU];
    logic [7:0]  cpu_prio  [NCPU];
    logic [31:0] cpu_stamp [NCPU];
    logic [1:0]  cur_mode;
    logic [15:0] cur_weight;
    logic [4:0]  cur_cpus;

    res_t   pending_results[$];
    bit     idle_on;
    int     mismatches;
    longint cycles;
    int     n_items, n_picks, n_preempts, n_overflows;
    logic [31:0] clock_now;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("timeout after %0d cycles, %0d results pending", cycles,
                         pending_results.size());
                $display("** aging_priority_ready_queue: FAILED **");
                $finish;
            end
        end
    end

    function automatic longint unsigned aged_prio(logic [7:0] prio, logic [31:0] stamp,
                                                  logic [31:0] now);
        logic [31:0] waited;
        waited = now - stamp;
        return longint'(prio) + longint'(waited) * longint'(cur_weight);
    endfunction

    function automatic bit rq_push(logic [7:0] pid, logic [7:0] prio, logic [31:0] stamp);
        if (rq_count >= QDEPTH) return 1'b0;
        rq_pid[rq_count]   = pid;
        rq_prio[rq_count]  = prio;
        rq_stamp[rq_count] = stamp;
        rq_count++;
        return 1'b1;
    endfunction

    // computes the result of one item and advances the shadow state
    function automatic res_t predict_step(logic [1:0] op, logic [3:0] cpu, logic [7:0] pid,
                                          logic [7:0] prio, logic [31:0] now);
        res_t r;
        int n, sel, target;
        bit any_idle;
        longint unsigned best, v, low, mine;
        r = '0;
        n = (cur_cpus < 1) ? 1 : (cur_cpus > NCPU) ? NCPU : int'(cur_cpus);
        if (op == OP_WAKE) begin
            if (!rq_push(pid, prio, now)) begin
                r.ov = 1'b1;
            end else if (cur_mode == MODE_AGING) begin
                any_idle = 1'b0;
                mine = longint'(prio);
                low = mine;
                target = 0;
                for (int i = 0; i < n; i++) begin
                    if (!cpu_busy[i]) begin
                        any_idle = 1'b1;
                        break;
                    end
                    v = aged_prio(cpu_prio[i], cpu_stamp[i], now);
                    if (v < low) begin
                        low = v;
                        target = i;
                    end
                end
                if (!any_idle && low < mine) begin
                    r.qv = 1'b1;
                    r.qc = target[3:0];
                end
            end
        end else if ((op == OP_SCHED || op == OP_PREEMPT) && cpu < n) begin
            if (op == OP_PREEMPT && cpu_busy[cpu]) begin
                if (!rq_push(cpu_pid[cpu], cpu_prio[cpu], now)) r.ov = 1'b1;
                cpu_busy[cpu] = 1'b0;
            end
            if (rq_count == 0) begin
                cpu_busy[cpu] = 1'b0;
            end else begin
                sel = 0;
                if (cur_mode == MODE_AGING) begin
                    best = aged_prio(rq_prio[0], rq_stamp[0], now);
                    for (int i = 1; i < rq_count; i++) begin
                        v = aged_prio(rq_prio[i], rq_stamp[i], now);
                        if (v > best) begin
                            best = v;
                            sel = i;
                        end
                    end
                end
                cpu_busy[cpu]  = 1'b1;
                cpu_pid[cpu]   = rq_pid[sel];
                cpu_prio[cpu]  = rq_prio[sel];
                cpu_stamp[cpu] = rq_stamp[sel];
                for (int i = sel; i + 1 < rq_count; i++) begin
                    rq_pid[i]   = rq_pid[i + 1];
                    rq_prio[i]  = rq_prio[i + 1];
                    rq_stamp[i] = rq_stamp[i + 1];
                end
                rq_count--;
                r.pv = 1'b1;
                r.pp = cpu_pid[cpu];
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[14:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h at cycle %0d", m_tdata, cycles);
            end else begin
                want = pending_results.pop_front();
                if (got.pv !== want.pv || got.pp !== want.pp || got.qv !== want.qv ||
                    got.qc !== want.qc || got.ov !== want.ov || m_tdata[15] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp pv=%0d pp=%0d qv=%0d qc=%0d ov=%0d, got pv=%0d pp=%0d qv=%0d qc=%0d ov=%0d",
                                 cycles, want.pv, want.pp, want.qv, want.qc, want.ov,
                                 got.pv, got.pp, got.qv, got.qc, got.ov);
                end
            end
        end
    end

    // result side stalls
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // sends one item and records its expected result at acceptance
    task automatic send_op(logic [1:0] op, logic [3:0] cpu, logic [7:0] pid,
                           logic [7:0] prio, logic [31:0] now);
        res_t r;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tdata  <= {2'b00, now, prio, pid, cpu, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = predict_step(op, cpu, pid, prio, now);
        pending_results.push_back(r);
        n_items++;
        n_picks     += r.pv;
        n_preempts  += r.qv;
        n_overflows += r.ov;
    endtask

    // stops sending and lets every pending result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MODE)   cur_mode   = val[1:0];
        if (idx == CFG_WEIGHT) cur_weight = val;
        if (idx == CFG_CPUS)   cur_cpus   = val[4:0];
    endtask

    task automatic set_config(logic [1:0] mode, logic [15:0] weight, logic [4:0] cpus);
        drain();
        write_reg(CFG_MODE, {14'd0, mode});
        write_reg(CFG_WEIGHT, weight);
        write_reg(CFG_CPUS, {11'd0, cpus});
    endtask

    // time mostly moves forward, with rare big jumps and steps backward
    function automatic logic [31:0] next_time();
        int pick;
        pick = $urandom_range(0, 59);
        if (pick == 0) clock_now = $urandom;
        else if (pick == 1) clock_now = clock_now - $urandom_range(1, 40);
        else clock_now = clock_now + $urandom_range(0, 30);
        return clock_now;
    endfunction

    task automatic random_op(int wake_pct, int cpu_hi);
        int roll;
        logic [1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < wake_pct) op = OP_WAKE;
        else if (roll < wake_pct + (100 - wake_pct) * 6 / 10) op = OP_SCHED;
        else if (roll < 97) op = OP_PREEMPT;
        else op = OP_NONE;
        send_op(op, 4'($urandom_range(0, cpu_hi)), 8'($urandom), 8'($urandom), next_time());
    endtask

    task automatic test_directed();
        // defaults: first-come, one cpu
        send_op(OP_SCHED,   4'd0,  8'd0,   8'd0,   32'd0);
        send_op(OP_PREEMPT, 4'd0,  8'd0,   8'd0,   32'd1);
        send_op(OP_WAKE,    4'd0,  8'hFF,  8'hFF,  32'd2);
        send_op(OP_WAKE,    4'hF,  8'h00,  8'h00,  32'd3);
        send_op(OP_SCHED,   4'd0,  8'd0,   8'd0,   32'd4);
        send_op(OP_SCHED,   4'hF,  8'd0,   8'd0,   32'd5);
        send_op(OP_PREEMPT, 4'd0,  8'd0,   8'd0,   32'd6);
        send_op(OP_NONE,    4'hF,  8'hFF,  8'hFF,  32'hFFFF_FFFF);
        send_op(OP_PREEMPT, 4'd3,  8'd0,   8'd0,   32'd7);
        // aging with preemption requests and a wrapped clock
        set_config(MODE_AGING, 16'hFFFF, 5'd2);
        send_op(OP_WAKE,    4'd0,  8'd10,  8'd5,   32'hFFFF_FFF0);
        send_op(OP_WAKE,    4'd0,  8'd11,  8'd9,   32'hFFFF_FFF8);
        send_op(OP_SCHED,   4'd0,  8'd0,   8'd0,   32'hFFFF_FFFE);
        send_op(OP_SCHED,   4'd1,  8'd0,   8'd0,   32'h0000_0004);
        send_op(OP_WAKE,    4'd0,  8'd12,  8'd200, 32'h0000_0004);
        send_op(OP_WAKE,    4'd0,  8'd13,  8'd0,   32'h0000_0005);
        send_op(OP_SCHED,   4'd2,  8'd0,   8'd0,   32'h0000_0006);
        send_op(OP_PREEMPT, 4'd1,  8'd0,   8'd0,   32'h0000_0006);
        send_op(OP_SCHED,   4'd0,  8'd0,   8'd0,   32'h0000_0007);
        clock_now = 32'd100;
    endtask

    task automatic test_overflow();
        set_config(MODE_AGING, 16'd3, 5'd1);
        for (int i = 0; i < QDEPTH + 4; i++)
            send_op(OP_WAKE, 4'($urandom), 8'($urandom), 8'($urandom), next_time());
        send_op(OP_SCHED, 4'd0, 8'd0, 8'd0, next_time());
        send_op(OP_WAKE, 4'd0, 8'd1, 8'd1, next_time());
        send_op(OP_PREEMPT, 4'd0, 8'd0, 8'd0, next_time());
        for (int i = 0; i < 70; i++)
            send_op(OP_SCHED, 4'd0, 8'd0, 8'd0, next_time());
    endtask

    task automatic test_phase(logic [1:0] mode, logic [15:0] weight, logic [4:0] cpus,
                              int items);
        int cpu_hi;
        set_config(mode, weight, cpus);
        cpu_hi = (cpus < 1) ? 0 : (cpus > 15) ? 15 : int'(cpus) - 1;
        for (int i = 0; i < items; i++) begin
            // mostly in-range cpus, some out of range
            if ($urandom_range(0, 4) == 0) random_op(50, 15);
            else random_op(($urandom_range(0, 3) == 0) ? 80 : 50, cpu_hi);
        end
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= CFG_MODE;
        cfg_wdata  <= '0;
        idle_on     = 1'b1;
        mismatches  = 0;
        n_items = 0; n_picks = 0; n_preempts = 0; n_overflows = 0;
        rq_count    = 0;
        foreach (cpu_busy[i]) cpu_busy[i] = 1'b0;
        cur_mode = MODE_FCFS; cur_weight = '0; cur_cpus = 5'd1;
        clock_now = 32'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_phase(MODE_FCFS,  16'd0,     5'd1,  200);
        test_phase(MODE_RR,    16'd5,     5'd4,  200);
        test_phase(MODE_AGING, 16'd1,     5'd16, 220);
        test_phase(MODE_AGING, 16'hFFFF,  5'd3,  220);
        test_phase(MODE_AGING, 16'd0,     5'd0,  200);
        test_phase(MODE_SPARE, 16'd7,     5'd31, 200);
        test_phase(MODE_AGING, 16'd300,   5'd8,  200);
        idle_on = 1'b0;
        test_phase(MODE_AGING, 16'd2,     5'd16, 200);
        drain();

        $display("%0d items: %0d picks, %0d preemption requests, %0d overflows",
                 n_items, n_picks, n_preempts, n_overflows);
        $display("modes fcfs, round robin, aging and spare; cpu counts 0 to 31");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** aging_priority_ready_queue: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** aging_priority_ready_queue: FAILED **");
        end
        $finish;
    end

endmodule

>>> aging_priority_ready_queue.f
rtl/apq_pkg.sv
rtl/apq_ram.sv
rtl/apq_aged.sv
rtl/aging_priority_ready_queue.sv
verif/aging_priority_ready_queue_tb.sv
